// ----- rtl/fcct_pkg.sv -----
package fcct_pkg;

    // Item codes carried in the op field.
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_READ  = 3'd2;
    localparam logic [2:0] OP_ACK   = 3'd3;
    localparam logic [2:0] OP_EOI   = 3'd4;

    // Bit positions within a channel's mode word.
    localparam int MODE_INT_EN  = 7;
    localparam int MODE_COUNTER = 6;
    localparam int MODE_PRE128  = 5;
    localparam int MODE_TC_NEXT = 2;
    localparam int MODE_HALT    = 1;
    localparam int MODE_CONTROL = 0;

    localparam logic [7:0] MODE_RESET     = 8'h23;
    localparam logic [7:0] MODE_TC_CLEAR  = 8'hf9;
    localparam logic [7:0] VECTOR_MASK    = 8'hf8;
    localparam logic [15:0] COUNT_RESET   = 16'd32768;
    localparam logic [2:0] SHIFT_RESET    = 3'd7;
    localparam logic [2:0] SHIFT_PRE128   = 3'd7;
    localparam logic [2:0] SHIFT_PRE8     = 3'd3;
    localparam logic [2:0] SHIFT_COUNTER  = 3'd0;
    localparam logic [1:0] CH_LAST        = 2'd3;

    localparam int NUM_CHANNELS = 4;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] channel;
        logic [7:0] wdata;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] int_vector;
        logic       int_taken;
        logic       int_request;
    } out_item_t;

endpackage

// ----- rtl/fcct_stream_if.sv -----
interface fcct_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

// ----- rtl/four_channel_counter_timer.sv -----
// Four-channel counter/timer in the style of a classic CTC peripheral.
//
// Channels: "item" is the input stream (op, channel, wdata) and "result" is
// the output stream (read_data, int_vector, int_taken, int_request). Both use
// a valid/ready handshake; a transfer happens on a rising edge of clk with
// valid and ready both high. Every input transfer yields exactly one result.
//
// Timing: the item is decoded and the channel state updated in the cycle of
// its transfer, and the result is held in the output register from the next
// cycle on. One item is taken every cycle while the output is not stalled;
// the single output register sets that figure, as the next item is taken in
// the same cycle that the held result is transferred out.
//
// Stall: while a result waits with ready low, item.ready is low and the
// channel state is frozen, so no tick is lost or counted twice.
//
// Reset (rst_n low, asynchronous): every channel is halted with mode 0x23 and
// a count of 32768, the vector base and all pending bits are cleared, and no
// result is valid.
module four_channel_counter_timer
    import fcct_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    fcct_stream_if.sink   item,
    fcct_stream_if.source result
);

    // Channel state.
    logic [7:0]  mode_reg       [NUM_CHANNELS];
    logic [7:0]  mode_next      [NUM_CHANNELS];
    logic [15:0] count_reg      [NUM_CHANNELS];
    logic [15:0] count_next     [NUM_CHANNELS];
    logic [15:0] reload_reg     [NUM_CHANNELS];
    logic [15:0] reload_next    [NUM_CHANNELS];
    logic [2:0]  shift_reg      [NUM_CHANNELS];
    logic [2:0]  shift_next     [NUM_CHANNELS];
    logic [7:0]  span_reg       [NUM_CHANNELS];
    logic [7:0]  span_next      [NUM_CHANNELS];
    logic [7:0]  tc_byte_reg    [NUM_CHANNELS];
    logic [7:0]  tc_byte_next   [NUM_CHANNELS];

    // Shared interrupt state.
    logic [7:0]  base_reg;
    logic [7:0]  base_next;
    logic [3:0]  pending_reg;
    logic [3:0]  pending_next;
    logic [1:0]  service_reg;
    logic [1:0]  service_next;

    // Output register.
    logic        out_valid_reg;
    out_item_t   out_reg;
    out_item_t   out_next;

    in_item_t    cur;
    logic        accept;

    // Tick helpers.
    logic [3:0]  running;
    logic [3:0]  pulse;
    logic [3:0]  at_end;
    logic [3:0]  hit;

    // Port write helpers.
    logic [8:0]  tc_count;
    logic [2:0]  tc_shift;
    logic [15:0] tc_scaled;

    // End of interrupt helpers.
    logic [15:0] moved;

    assign cur          = item.payload;
    assign item.ready   = !out_valid_reg || result.ready;
    assign accept       = item.valid && item.ready;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    always_comb
    begin
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            mode_next[c]    = mode_reg[c];
            count_next[c]   = count_reg[c];
            reload_next[c]  = reload_reg[c];
            shift_next[c]   = shift_reg[c];
            span_next[c]    = span_reg[c];
            tc_byte_next[c] = tc_byte_reg[c];
            running[c]      = !mode_reg[c][MODE_HALT];
            at_end[c]       = count_reg[c] <= 16'd1;
        end
        base_next    = base_reg;
        pending_next = pending_reg;
        service_next = service_reg;
        out_next     = '0;

        // Channel 3 in counter mode is clocked by channel 0 reloads; the
        // others, and channel 3 in timer mode, by every tick.
        pulse[0] = running[0];
        pulse[1] = running[1];
        pulse[2] = running[2];
        pulse[3] = running[3]
            && (!mode_reg[3][MODE_COUNTER] || (running[0] && at_end[0]));
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            hit[c] = pulse[c] && at_end[c] && mode_reg[c][MODE_INT_EN];
        end

        // A time constant of zero stands for 256; timer mode prescales it.
        tc_count = (cur.wdata == 8'd0) ? 9'd256 : {1'b0, cur.wdata};
        if (mode_reg[cur.channel][MODE_COUNTER])
        begin
            tc_shift = SHIFT_COUNTER;
        end
        else if (mode_reg[cur.channel][MODE_PRE128])
        begin
            tc_shift = SHIFT_PRE128;
        end
        else
        begin
            tc_shift = SHIFT_PRE8;
        end
        tc_scaled = {7'd0, tc_count} << tc_shift;

        moved = (reload_reg[service_reg] >= count_reg[service_reg])
            ? reload_reg[service_reg] - count_reg[service_reg] : 16'd0;

        unique case (cur.op)
            OP_TICK:
            begin
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    if (pulse[c])
                    begin
                        count_next[c] = at_end[c] ? reload_reg[c] : count_reg[c] - 16'd1;
                    end
                end
                pending_next = pending_reg | hit;
            end
            OP_WRITE:
            begin
                if (mode_reg[cur.channel][MODE_TC_NEXT])
                begin
                    tc_byte_next[cur.channel] = cur.wdata;
                    shift_next[cur.channel]   = tc_shift;
                    reload_next[cur.channel]  = tc_scaled;
                    count_next[cur.channel]   = tc_scaled;
                    span_next[cur.channel]    = 8'd1 << tc_shift;
                    mode_next[cur.channel]    = mode_reg[cur.channel] & MODE_TC_CLEAR;
                end
                else if (cur.wdata[MODE_CONTROL])
                begin
                    mode_next[cur.channel] = cur.wdata;
                end
                else if (cur.channel == 2'd0)
                begin
                    base_next = cur.wdata & VECTOR_MASK;
                end
            end
            OP_READ:
            begin
                if (cur.channel != CH_LAST)
                begin
                    out_next.read_data = tc_byte_reg[cur.channel];
                end
                else
                begin
                    out_next.read_data = 8'(count_reg[CH_LAST] >> shift_reg[CH_LAST]);
                end
            end
            OP_ACK:
            begin
                // Pending channels with interrupts disabled are dropped; the
                // lowest enabled one is served.
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    if (pending_next[c])
                    begin
                        if (!mode_reg[c][MODE_INT_EN])
                        begin
                            pending_next[c] = 1'b0;
                        end
                        else if (!out_next.int_taken)
                        begin
                            out_next.int_taken  = 1'b1;
                            pending_next[c]     = 1'b0;
                            service_next        = 2'(c);
                            out_next.int_vector = base_reg + {5'd0, 2'(c), 1'b0};
                        end
                    end
                end
            end
            OP_EOI:
            begin
                // A repeat that arrived during service is dropped unless the
                // channel has moved less than one prescaled step since reload.
                if (pending_reg[service_reg] && (moved >= {8'd0, span_reg[service_reg]}))
                begin
                    pending_next[service_reg] = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        out_next.int_request = |pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                mode_reg[c]    <= MODE_RESET;
                count_reg[c]   <= COUNT_RESET;
                reload_reg[c]  <= COUNT_RESET;
                shift_reg[c]   <= SHIFT_RESET;
                span_reg[c]    <= 8'd0;
                tc_byte_reg[c] <= 8'd0;
            end
            base_reg      <= 8'd0;
            pending_reg   <= 4'd0;
            service_reg   <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    mode_reg[c]    <= mode_next[c];
                    count_reg[c]   <= count_next[c];
                    reload_reg[c]  <= reload_next[c];
                    shift_reg[c]   <= shift_next[c];
                    span_reg[c]    <= span_next[c];
                    tc_byte_reg[c] <= tc_byte_next[c];
                end
                base_reg    <= base_next;
                pending_reg <= pending_next;
                service_reg <= service_next;
            end
            if (item.ready)
            begin
                out_valid_reg <= item.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

    // The vector base is aligned to eight, so a served vector is always even
    // and an unserved one reads as zero.
    a_vector_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.int_taken ? !out_reg.int_vector[0]
                                              : out_reg.int_vector == 8'd0))
        else $error("interrupt vector malformed");

    // An acknowledge never raises a new pending bit.
    a_ack_no_new: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cur.op == OP_ACK) |=> (pending_reg & ~$past(pending_reg)) == 4'd0)
        else $error("acknowledge set a pending bit");

    // The request flag of a held result agrees with the live pending mask.
    a_request_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.int_request == (|pending_reg))
        else $error("int_request out of step with pending mask");

    // A reload always restores a nonzero count, so no count ever rests at zero.
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[0] != 16'd0 && count_reg[1] != 16'd0
        && count_reg[2] != 16'd0 && count_reg[3] != 16'd0)
        else $error("down count reached zero");

endmodule

// ----- dv/tb_four_channel_counter_timer.sv -----
`timescale 1ns / 1ps

module tb_four_channel_counter_timer;
    import fcct_pkg::*;

    // The package names five item codes; the remaining three codes of the op
    // field must be accepted and leave every channel untouched.
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int MAX_GAP      = 18;
    localparam int MAX_REPORTED = 10;

    logic clk = 1'b0;
    logic rst_n;

    fcct_stream_if #(.payload_t(in_item_t))  item_ch ();
    fcct_stream_if #(.payload_t(out_item_t)) result_ch ();

    four_channel_counter_timer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // Predicted channel state, kept in step with every accepted transfer.
    logic [7:0]  mode_q   [NUM_CHANNELS];
    logic [15:0] count_q  [NUM_CHANNELS];
    logic [15:0] reload_q [NUM_CHANNELS];
    logic [2:0]  shift_q  [NUM_CHANNELS];
    logic [7:0]  span_q   [NUM_CHANNELS];
    logic [7:0]  tconst_q [NUM_CHANNELS];
    logic [7:0]  vbase_q;
    logic [3:0]  pend_q;
    logic [1:0]  serving_q;

    // Results still owed by the block, oldest first.
    out_item_t awaited_q [$];

    int  fail_count = 0;
    int  sent_count = 0;
    // When clear, neither the sender nor the receiver inserts idle cycles.
    bit  gaps_on    = 1'b1;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Puts the predicted state into its post-reset condition: all channels
    // halted in timer mode with the large prescaler and a full count.
    task automatic clear_prediction();
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            mode_q[c]   = MODE_RESET;
            count_q[c]  = COUNT_RESET;
            reload_q[c] = COUNT_RESET;
            shift_q[c]  = SHIFT_RESET;
            span_q[c]   = '0;
            tconst_q[c] = '0;
        end
        vbase_q   = '0;
        pend_q    = '0;
        serving_q = '0;
    endtask

    // One count pulse on a channel. A count of one (or zero) wraps back to
    // the reload value, and the wrap is reported to the caller.
    function automatic bit count_down(int c);
        if (count_q[c] <= 16'd1)
        begin
            count_q[c] = reload_q[c];
            return 1'b1;
        end
        count_q[c] = count_q[c] - 16'd1;
        return 1'b0;
    endfunction

    // Advances the predicted state by one item and returns the result the
    // block must produce for it.
    function automatic out_item_t predict_ctc(in_item_t it);
        out_item_t  r;
        logic [3:0] hit;
        logic [3:0] p;
        logic [7:0] v;
        int         c;
        int         cnt;
        int         sh;
        int         moved;
        bit         ch0_wrap;

        r        = '0;
        hit      = '0;
        ch0_wrap = 1'b0;
        c        = int'(it.channel);
        v        = it.wdata;
        case (it.op)
            OP_TICK:
            begin
                // Channel 0 goes first because channel 3 in counter mode
                // takes its pulse from a channel 0 wrap in the same tick.
                if (!mode_q[0][MODE_HALT] && count_down(0))
                begin
                    ch0_wrap = 1'b1;
                    hit[0]   = mode_q[0][MODE_INT_EN];
                end
                if (!mode_q[3][MODE_HALT] && (mode_q[3][MODE_COUNTER] ? ch0_wrap : 1'b1)
                    && count_down(3))
                    hit[3] = mode_q[3][MODE_INT_EN];
                for (int i = 1; i < 3; i++)
                begin
                    if (!mode_q[i][MODE_HALT] && count_down(i))
                        hit[i] = mode_q[i][MODE_INT_EN];
                end
                pend_q = pend_q | hit;
            end
            OP_WRITE:
            begin
                if (mode_q[c][MODE_TC_NEXT])
                begin
                    cnt = (v == 8'd0) ? 256 : int'(v);
                    if (mode_q[c][MODE_COUNTER])
                        sh = int'(SHIFT_COUNTER);
                    else
                        sh = mode_q[c][MODE_PRE128] ? int'(SHIFT_PRE128) : int'(SHIFT_PRE8);
                    tconst_q[c] = v;
                    shift_q[c]  = 3'(sh);
                    reload_q[c] = 16'(cnt << sh);
                    count_q[c]  = 16'(cnt << sh);
                    span_q[c]   = 8'(1 << sh);
                    mode_q[c]   = mode_q[c] & MODE_TC_CLEAR;
                end
                else if (v[MODE_CONTROL])
                    mode_q[c] = v;
                else if (c == 0)
                    vbase_q = v & VECTOR_MASK;
            end
            OP_READ:
            begin
                if (it.channel != CH_LAST)
                    r.read_data = tconst_q[c];
                else
                    r.read_data = 8'(count_q[CH_LAST] >> shift_q[CH_LAST]);
            end
            OP_ACK:
            begin
                // Pending channels whose interrupts have since been disabled
                // are dropped on the way to the lowest enabled one.
                p = pend_q;
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    if (p[i])
                    begin
                        if (!mode_q[i][MODE_INT_EN])
                            p[i] = 1'b0;
                        else if (!r.int_taken)
                        begin
                            r.int_taken  = 1'b1;
                            p[i]         = 1'b0;
                            serving_q    = 2'(i);
                            r.int_vector = vbase_q + 8'(2 * i);
                        end
                    end
                end
                pend_q = p;
            end
            OP_EOI:
            begin
                // A repeat request is only kept if the channel has not yet
                // moved a whole prescaled step since it last reloaded.
                if (pend_q[serving_q])
                begin
                    moved = (reload_q[serving_q] >= count_q[serving_q])
                        ? int'(reload_q[serving_q]) - int'(count_q[serving_q]) : 0;
                    if (moved >= int'(span_q[serving_q]))
                        pend_q[serving_q] = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        r.int_request = |pend_q;
        return r;
    endfunction

    function automatic logic [7:0] mode_byte(bit ie, bit counter, bit pre128, bit tc_next,
                                             bit halt);
        logic [7:0] m;

        m               = '0;
        m[MODE_INT_EN]  = ie;
        m[MODE_COUNTER] = counter;
        m[MODE_PRE128]  = pre128;
        m[MODE_TC_NEXT] = tc_next;
        m[MODE_HALT]    = halt;
        m[MODE_CONTROL] = 1'b1;
        return m;
    endfunction

    // Offers one item after a random number of idle cycles and waits for its
    // transfer. Valid is left high afterwards so that back-to-back items go
    // through without a bubble; the next call lowers it if it idles.
    task automatic send_item(logic [2:0] op, logic [1:0] ch, logic [7:0] wd);
        in_item_t it;
        int       gap;

        it.op      = op;
        it.channel = ch;
        it.wdata   = wd;
        gap        = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        awaited_q.push_back(predict_ctc(it));
        sent_count++;
    endtask

    // Compares one transferred result with the oldest expectation.
    task automatic check_result(out_item_t got);
        out_item_t want;

        if (awaited_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTED)
                $display("%0t: result with nothing awaited: rd=%02h vec=%02h taken=%0b req=%0b",
                         $realtime, got.read_data, got.int_vector, got.int_taken,
                         got.int_request);
            return;
        end
        want = awaited_q.pop_front();
        if (got.read_data !== want.read_data || got.int_vector !== want.int_vector ||
            got.int_taken !== want.int_taken || got.int_request !== want.int_request)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTED)
                $display("%0t: result mismatch: expected rd=%02h vec=%02h taken=%0b req=%0b",
                         $realtime, want.read_data, want.int_vector, want.int_taken,
                         want.int_request,
                         ", got rd=%02h vec=%02h taken=%0b req=%0b",
                         got.read_data, got.int_vector, got.int_taken, got.int_request);
        end
    endtask

    // Result side: ready is withheld for a random number of cycles before
    // each result, then held high until a transfer takes place.
    initial
    begin
        int hold;

        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            if (hold != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (result_ch.valid !== 1'b1);
            check_result(result_ch.payload);
        end
    end

    // Straight after reset every channel is halted, so ticks change nothing,
    // an acknowledge finds nothing to serve and the spare op codes are inert.
    // Channel 3 reads back its full count of 32768 scaled down by 128.
    task automatic test_idle_after_reset();
        send_item(OP_READ, 2'd0, 8'h00);
        send_item(OP_READ, 2'd3, 8'h00);
        send_item(OP_TICK, 2'd0, 8'h00);
        send_item(OP_ACK, 2'd0, 8'h00);
        send_item(OP_EOI, 2'd0, 8'h00);
        send_item(OP_SPARE_5, 2'd3, 8'hff);
        send_item(OP_SPARE_6, 2'd1, 8'h55);
        send_item(OP_SPARE_7, 2'd2, 8'haa);
    endtask

    // Vector base, an ignored write, and time constants at both extremes in
    // counter mode and both timer prescalers. A constant of zero means 256.
    task automatic test_port_writes();
        send_item(OP_WRITE, 2'd0, 8'hfe);
        send_item(OP_WRITE, 2'd2, 8'h00);
        send_item(OP_WRITE, 2'd0, mode_byte(1'b1, 1'b1, 1'b0, 1'b1, 1'b0));
        send_item(OP_WRITE, 2'd0, 8'h01);
        send_item(OP_WRITE, 2'd3, mode_byte(1'b1, 1'b1, 1'b0, 1'b1, 1'b0));
        send_item(OP_WRITE, 2'd3, 8'h00);
        send_item(OP_WRITE, 2'd1, mode_byte(1'b1, 1'b0, 1'b1, 1'b1, 1'b0));
        send_item(OP_WRITE, 2'd1, 8'hff);
        send_item(OP_WRITE, 2'd2, mode_byte(1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
        send_item(OP_WRITE, 2'd2, 8'h02);
        send_item(OP_READ, 2'd1, 8'h00);
    endtask

    // Channel 0 now wraps on every tick, which both raises its interrupt and
    // clocks channel 3 down by one. The acknowledge returns the vector base,
    // and an end of interrupt right after a reload keeps the repeat request.
    task automatic test_interrupt_service();
        send_item(OP_TICK, 2'd0, 8'h00);
        send_item(OP_READ, 2'd3, 8'h00);
        send_item(OP_ACK, 2'd0, 8'h00);
        send_item(OP_TICK, 2'd0, 8'h00);
        send_item(OP_EOI, 2'd0, 8'h00);
        send_item(OP_ACK, 2'd0, 8'h00);
    endtask

    // Mostly well-formed traffic: channel set-up pairs with short time
    // constants so that channels wrap often, runs of ticks, acknowledge and
    // end-of-interrupt pairs and reads. The rest is unconstrained noise.
    task automatic run_random(int count);
        int         first;
        int         kind;
        int         c;
        int         runs;
        logic [7:0] ctrl;
        logic [7:0] tc;

        first = sent_count;
        while (sent_count - first < count)
        begin
            // Idling is switched on or off for stretches of roughly a hundred
            // items, so both back-to-back and sparse traffic are seen.
            if ($urandom_range(0, 99) == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            kind = $urandom_range(0, 99);
            c    = $urandom_range(0, 3);
            if (kind < 20)
            begin
                ctrl = mode_byte($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 3) == 0, $urandom_range(0, 7) != 0,
                                 $urandom_range(0, 3) == 0);
                ctrl[4:3] = 2'($urandom_range(0, 3));
                send_item(OP_WRITE, 2'(c), ctrl);
                if (ctrl[MODE_TC_NEXT])
                begin
                    if ($urandom_range(0, 7) == 0)
                        tc = 8'($urandom_range(0, 255));
                    else if (ctrl[MODE_COUNTER])
                        tc = 8'($urandom_range(1, 6));
                    else
                        tc = 8'($urandom_range(1, 3));
                    send_item(OP_WRITE, 2'(c), tc);
                end
            end
            else if (kind < 25)
                send_item(OP_WRITE, 2'd0, 8'($urandom_range(0, 255)) & 8'hfe);
            else if (kind < 60)
            begin
                runs = $urandom_range(1, 24);
                repeat (runs) send_item(OP_TICK, 2'($urandom_range(0, 3)),
                                        8'($urandom_range(0, 255)));
            end
            else if (kind < 72)
            begin
                send_item(OP_ACK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                runs = $urandom_range(0, 3);
                repeat (runs) send_item(OP_TICK, 2'd0, 8'h00);
                send_item(OP_EOI, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
            else if (kind < 80)
                send_item(OP_EOI, 2'(c), 8'($urandom_range(0, 255)));
            else if (kind < 88)
                send_item(OP_READ, 2'(c), 8'($urandom_range(0, 255)));
            else
                send_item(3'($urandom_range(0, 7)), 2'(c), 8'($urandom_range(0, 255)));
        end
    endtask

    // The sender stops until every result is back, so the block is seen going
    // completely quiet on both sides and then picking up again.
    task automatic test_drain_pause();
        run_random(50);
        item_ch.valid <= 1'b0;
        wait (awaited_q.size() == 0);
        repeat (6) @(posedge clk);
        run_random(50);
    endtask

    initial
    begin
        item_ch.valid   <= 1'b0;
        item_ch.payload <= '0;
        rst_n = 1'b0;
        clear_prediction();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_after_reset();
        test_port_writes();
        test_interrupt_service();
        run_random(1625);
        test_drain_pause();

        item_ch.valid <= 1'b0;
        wait (awaited_q.size() == 0);
        // The wait that follows catches any stray extra result.
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // The slowest correct run, with the longest gap and the longest stall on
    // every item, stays well below this figure.
    initial
    begin
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
